// ----- sv/three_phase_sine_duty_gen_assert.svh -----
// assertion macros for the three-phase sine duty generator
// no dependencies; included by the top level, which checks its own logic
`ifndef THREE_PHASE_SINE_DUTY_GEN_ASSERT_SVH
`define THREE_PHASE_SINE_DUTY_GEN_ASSERT_SVH

// same-cycle implication
`define TPSD_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("tpsd same-cycle check failed");

// next-cycle implication
`define TPSD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("tpsd next-cycle check failed");

`endif

// ----- sv/tpsd_pkg.sv -----
// shared constants, types and the sine table builder for the duty generator
// no dependencies
package tpsd_pkg;

	localparam int PWM_BITS        = 10;
	localparam int SINE_TABLE_BITS = 10;
	localparam int ANGLE_W         = 16;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int MAG_W           = 17;
	localparam int PROD_W          = 32;
	localparam int DUTY_W          = PROD_W + 1;
	localparam int SINE_N          = 1 << SINE_TABLE_BITS;
	localparam int ADDR_W          = SINE_TABLE_BITS + 1;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH    = 1'd1;

	localparam logic signed [CFG_W-1:0] PHASE_OFFSET_RST = -16'sd3129;
	localparam logic [CFG_W-1:0]        MOD_DEPTH_RST    = 16'd22938;

	// one third and two thirds of a turn
	localparam logic [ANGLE_W-1:0] PHASE_B_STEP = 16'd21845;
	localparam logic [ANGLE_W-1:0] PHASE_C_STEP = 16'd43691;

	localparam logic [PWM_BITS-1:0] PWM_FULL = {PWM_BITS{1'b1}};
	localparam logic [DUTY_W-1:0]   DUTY_MID = DUTY_W'(1) << PROD_W;

	typedef logic [MAG_W-1:0] sine_rom_t [SINE_N+1];

	typedef struct packed {
		logic en_s3;
		logic en_out;
	} duty_en_t;

	// quarter-wave sine in q16, odd degree-9 polynomial with q30 horner steps
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint unsigned x;
		longint unsigned y;
		longint unsigned s;
		longint unsigned r;
		for (int k = 0; k <= SINE_N; k++) begin
			x = 64'(k) << (30 - SINE_TABLE_BITS);
			y = (x * x) >> 30;
			s = 64'd172272;
			s = 64'd5026994 - ((s * y) >> 30);
			s = 64'd85569306 - ((s * y) >> 30);
			s = 64'd693598669 - ((s * y) >> 30);
			s = 64'd1686629713 - ((s * y) >> 30);
			r = (s * x) >> 30;
			r = (r + 64'd8192) >> 14;
			if (r > 64'd65536)
				r = 64'd65536;
			rom[k] = MAG_W'(r);
		end
		return rom;
	endfunction

endpackage

// ----- sv/tpsd_sine_rom.sv -----
// quadrant fold and registered quarter-wave sine table read for one phase
// depends on tpsd_pkg
module tpsd_sine_rom
	import tpsd_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [ANGLE_W-1:0] angle,
	output logic [MAG_W-1:0]   mag_s2,
	output logic               neg_s2
);

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [ADDR_W-1:0]          addr;

	assign quad = angle[ANGLE_W-1 -: 2];
	assign idx  = angle[ANGLE_W-3 -: SINE_TABLE_BITS];

	// odd quadrants read the table mirrored
	assign addr = quad[0] ? (ADDR_W'(SINE_N) - {1'b0, idx}) : {1'b0, idx};

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= SINE_ROM[addr];
			neg_s2 <= quad[1];
		end
	end

endmodule

// ----- sv/tpsd_duty.sv -----
// depth scaling and high/low side split for one phase, product stage and result register
// depends on tpsd_pkg
module tpsd_duty
	import tpsd_pkg::*;
(
	input  logic                clk,
	input  duty_en_t            en,
	input  logic [MAG_W-1:0]    mag,
	input  logic                neg,
	input  logic [CFG_W-1:0]    depth,
	output logic [PWM_BITS-1:0] high_q,
	output logic [PWM_BITS-1:0] low_q
);

	logic [PROD_W-1:0]   prod_s3;
	logic                neg_s3;
	logic [DUTY_W-1:0]   duty;
	logic [PWM_BITS-1:0] whole;
	logic                below_mid;

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			prod_s3 <= PROD_W'(PROD_W'(depth) * PROD_W'(mag));
			neg_s3  <= neg;
		end
	end

	// duty in units of 2^-(33-PWM_BITS) count around mid-scale
	assign duty      = neg_s3 ? (DUTY_MID - DUTY_W'(prod_s3)) : (DUTY_MID + DUTY_W'(prod_s3));
	assign whole     = duty[DUTY_W-1 -: PWM_BITS];
	assign below_mid = neg_s3 && (prod_s3 != '0);

	always_ff @(posedge clk) begin
		if (en.en_out) begin
			if (below_mid) begin
				low_q  <= whole;
				high_q <= PWM_FULL - whole;
			end else begin
				high_q <= whole;
				low_q  <= PWM_FULL - whole;
			end
		end
	end

endmodule

// ----- sv/three_phase_sine_duty_gen.sv -----
// top level of the three-phase sine pwm duty generator
// depends on tpsd_pkg, tpsd_sine_rom, tpsd_duty, three_phase_sine_duty_gen_assert.svh
//
// channel   signals                         moves
// input     in_valid / in_ready             one rotor_angle word
// output    out_valid / out_ready           six pwm compare values
// config    cfg_we / cfg_index / cfg_data   one register write, no wait
//
// one word accepted per cycle unless the pipe is full and out_ready is low; out_valid rises with the result register
// stages: angle register, sine table read, depth product, result register
// each stage holds its word under output stall and fills its bubbles
// in_ready drops only when all four stages hold a word
// reset clears valid flags and loads the register reset values
`include "three_phase_sine_duty_gen_assert.svh"

module three_phase_sine_duty_gen
	import tpsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ANGLE_W-1:0]   rotor_angle,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PWM_BITS-1:0]  phase_a_high,
	output logic [PWM_BITS-1:0]  phase_a_low,
	output logic [PWM_BITS-1:0]  phase_b_high,
	output logic [PWM_BITS-1:0]  phase_b_low,
	output logic [PWM_BITS-1:0]  phase_c_high,
	output logic [PWM_BITS-1:0]  phase_c_low,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic signed [CFG_W-1:0] phase_offset_q;
	logic [CFG_W-1:0]        mod_depth_q;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3, en_out;
	duty_en_t duty_en;

	logic [ANGLE_W-1:0] ang_s1;
	logic [ANGLE_W-1:0] ang_b, ang_c;
	logic [MAG_W-1:0]   mag_a_s2, mag_b_s2, mag_c_s2;
	logic               neg_a_s2, neg_b_s2, neg_c_s2;
	logic               sides_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_offset_q <= PHASE_OFFSET_RST;
			mod_depth_q    <= MOD_DEPTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_OFFSET: phase_offset_q <= $signed(cfg_data);
				REG_MOD_DEPTH:    mod_depth_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// each stage moves when empty or when the next one moves
	assign en_out   = !out_valid || out_ready;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign duty_en.en_s3  = en_s3;
	assign duty_en.en_out = en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= in_valid;
			if (en_s2)
				v_s2 <= v_s1;
			if (en_s3)
				v_s3 <= v_s2;
			if (en_out)
				out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1)
			ang_s1 <= rotor_angle + $unsigned(phase_offset_q);
	end

	assign ang_b = ang_s1 + PHASE_B_STEP;
	assign ang_c = ang_s1 + PHASE_C_STEP;

	tpsd_sine_rom u_rom_a (
		.clk    (clk),
		.en     (en_s2),
		.angle  (ang_s1),
		.mag_s2 (mag_a_s2),
		.neg_s2 (neg_a_s2)
	);

	tpsd_sine_rom u_rom_b (
		.clk    (clk),
		.en     (en_s2),
		.angle  (ang_b),
		.mag_s2 (mag_b_s2),
		.neg_s2 (neg_b_s2)
	);

	tpsd_sine_rom u_rom_c (
		.clk    (clk),
		.en     (en_s2),
		.angle  (ang_c),
		.mag_s2 (mag_c_s2),
		.neg_s2 (neg_c_s2)
	);

	tpsd_duty u_duty_a (
		.clk    (clk),
		.en     (duty_en),
		.mag    (mag_a_s2),
		.neg    (neg_a_s2),
		.depth  (mod_depth_q),
		.high_q (phase_a_high),
		.low_q  (phase_a_low)
	);

	tpsd_duty u_duty_b (
		.clk    (clk),
		.en     (duty_en),
		.mag    (mag_b_s2),
		.neg    (neg_b_s2),
		.depth  (mod_depth_q),
		.high_q (phase_b_high),
		.low_q  (phase_b_low)
	);

	tpsd_duty u_duty_c (
		.clk    (clk),
		.en     (duty_en),
		.mag    (mag_c_s2),
		.neg    (neg_c_s2),
		.depth  (mod_depth_q),
		.high_q (phase_c_high),
		.low_q  (phase_c_low)
	);

	assign sides_full = ((phase_a_high ^ phase_a_low) == PWM_FULL) &&
		((phase_b_high ^ phase_b_low) == PWM_FULL) &&
		((phase_c_high ^ phase_c_low) == PWM_FULL);

	// backpressure reaches the input only with a full pipe
	`TPSD_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, !in_ready, v_s1 && v_s2 && v_s3 && out_valid)
	// an accepted word always lands in the angle stage
	`TPSD_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, v_s1)
	// a blocked product stage keeps its word
	`TPSD_ASSERT_NEXT(a_s3_held, clk, arst_n, v_s3 && !en_out, v_s3)
	// the two sides of every phase sum to full scale whenever out_valid is high
	`TPSD_ASSERT_NOW(a_sides_sum_full, clk, arst_n, out_valid, sides_full)

endmodule
